// ===== rtl/core/dcf_pkg.sv =====
package dcf_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_MIN  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_MAX  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ONE_MIN   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ONE_MAX   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_MIN = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_MAX = 3'd5;

    localparam int unsigned CFG_DATA_W = 16;

    // Threshold defaults after reset, in ms
    localparam logic [CFG_DATA_W-1:0] ZERO_MIN_DEFAULT  = 16'd40;
    localparam logic [CFG_DATA_W-1:0] ZERO_MAX_DEFAULT  = 16'd130;
    localparam logic [CFG_DATA_W-1:0] ONE_MIN_DEFAULT   = 16'd140;
    localparam logic [CFG_DATA_W-1:0] ONE_MAX_DEFAULT   = 16'd230;
    localparam logic [CFG_DATA_W-1:0] START_MIN_DEFAULT = 16'd1600;
    localparam logic [CFG_DATA_W-1:0] START_MAX_DEFAULT = 16'd2000;

    typedef enum logic [2:0] {
        CLS_IDLE  = 3'd0,
        CLS_GAP   = 3'd1,
        CLS_START = 3'd2,
        CLS_ZERO  = 3'd3,
        CLS_ONE   = 3'd4
    } pulse_class_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] zero_min_ms;
        logic [CFG_DATA_W-1:0] zero_max_ms;
        logic [CFG_DATA_W-1:0] one_min_ms;
        logic [CFG_DATA_W-1:0] one_max_ms;
        logic [CFG_DATA_W-1:0] start_min_ms;
        logic [CFG_DATA_W-1:0] start_max_ms;
    } dcf_cfg_t;

    typedef struct packed {
        logic        pin_level;
        logic [15:0] pulse_ms;
        logic [4:0]  clock_day;
        logic [3:0]  clock_month;
        logic [6:0]  clock_year;
    } dcf_beat_t;

    typedef struct packed {
        logic [2:0] pulse_class;
        logic       decode_failed;
        logic       commit;
        logic       date_from_signal;
        logic [6:0] out_minute;
        logic [5:0] out_hour;
        logic [5:0] out_day;
        logic [4:0] out_month;
        logic [7:0] out_year;
        logic [5:0] frame_position;
    } dcf_result_t;

endpackage

// ===== rtl/core/dcf_beat_if.sv =====
interface dcf_beat_if;
    import dcf_pkg::*;

    logic      valid;
    logic      ready;
    dcf_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/dcf_result_if.sv =====
interface dcf_result_if;
    import dcf_pkg::*;

    logic        valid;
    logic        ready;
    dcf_result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/dcf77_time_code_decoder.sv =====
// Channel   Modport  Beat carries                                   Accepted when
// pulse     sink     pin_level, pulse_ms, clock_day/month/year       valid && ready
// result    source   pulse_class, flags, decoded time, frame_position valid && ready
// config    write    write_en, reg_index, write_data                 write_en high
//
// One beat per cycle sustained while result is not stalled; a result passes through the input
// register, then one pass of frame logic into the result register, before it is presented.
// Reset restores the default windows and clears the frame decoder and both stages.
// While result is stalled the result register holds and one more beat can still enter
// the input register; pulse.ready then drops until the result moves on.
module dcf77_time_code_decoder (
    input  logic                             clk,
    input  logic                             rst_n,
    dcf_beat_if.sink                         pulse,
    dcf_result_if.source                     result,
    input  logic                             write_en,
    input  logic [dcf_pkg::CFG_INDEX_W-1:0]  reg_index,
    input  logic [dcf_pkg::CFG_DATA_W-1:0]   write_data
);
    import dcf_pkg::*;

    dcf_cfg_t    cfg_reg;
    dcf_beat_t   beat_reg;
    logic        beat_valid_reg;
    dcf_result_t result_reg;
    logic        result_valid_reg;
    dcf_result_t frame_res;
    logic        advance;

    // Move the held beat into the result register when the output has room
    assign advance     = beat_valid_reg && (!result_valid_reg || result.ready);
    assign pulse.ready = !beat_valid_reg || advance;

    assign result.valid = result_valid_reg;
    assign result.data  = result_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.zero_min_ms  <= ZERO_MIN_DEFAULT;
            cfg_reg.zero_max_ms  <= ZERO_MAX_DEFAULT;
            cfg_reg.one_min_ms   <= ONE_MIN_DEFAULT;
            cfg_reg.one_max_ms   <= ONE_MAX_DEFAULT;
            cfg_reg.start_min_ms <= START_MIN_DEFAULT;
            cfg_reg.start_max_ms <= START_MAX_DEFAULT;
        end
        else if (write_en)
        begin
            unique case (reg_index)
                CFG_ZERO_MIN:  cfg_reg.zero_min_ms  <= write_data;
                CFG_ZERO_MAX:  cfg_reg.zero_max_ms  <= write_data;
                CFG_ONE_MIN:   cfg_reg.one_min_ms   <= write_data;
                CFG_ONE_MAX:   cfg_reg.one_max_ms   <= write_data;
                CFG_START_MIN: cfg_reg.start_min_ms <= write_data;
                CFG_START_MAX: cfg_reg.start_max_ms <= write_data;
                default: ;
            endcase
        end
    end

    // Input stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            beat_valid_reg <= 1'b0;
        else if (pulse.ready)
            beat_valid_reg <= pulse.valid;
    end

    // Capture the input beat
    always_ff @(posedge clk)
    begin
        if (pulse.valid && pulse.ready)
            beat_reg <= pulse.data;
    end

    dcf_frame u_frame (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .beat  (beat_reg),
        .cfg   (cfg_reg),
        .res   (frame_res)
    );

    // Result stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (advance)
            result_valid_reg <= 1'b1;
        else if (result.ready)
            result_valid_reg <= 1'b0;
    end

    // Hold the result until taken
    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= frame_res;
    end

endmodule

// ===== rtl/core/dcf_frame.sv =====
module dcf_frame (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  dcf_pkg::dcf_beat_t   beat,
    input  dcf_pkg::dcf_cfg_t    cfg,
    output dcf_pkg::dcf_result_t res
);
    import dcf_pkg::*;

    // Frame positions
    localparam logic [5:0] POS_START_BIT = 6'd21;
    localparam logic [5:0] POS_MIN0      = 6'd22;
    localparam logic [5:0] POS_MIN_PAR   = 6'd29;
    localparam logic [5:0] POS_HOUR0     = 6'd30;
    localparam logic [5:0] POS_HOUR_PAR  = 6'd36;
    localparam logic [5:0] POS_DAY0      = 6'd37;
    localparam logic [5:0] POS_DOW0      = 6'd43;
    localparam logic [5:0] POS_MON0      = 6'd46;
    localparam logic [5:0] POS_YEAR0     = 6'd51;
    localparam logic [5:0] POS_DATE_PAR  = 6'd59;

    localparam logic [6:0] LAST_MINUTE = 7'd59;
    localparam logic [5:0] LAST_HOUR   = 6'd23;

    function automatic logic [7:0] bcd_weight(input logic [2:0] idx);
        logic [7:0] w;
        unique case (idx)
            3'd0: w = 8'd1;
            3'd1: w = 8'd2;
            3'd2: w = 8'd4;
            3'd3: w = 8'd8;
            3'd4: w = 8'd10;
            3'd5: w = 8'd20;
            3'd6: w = 8'd40;
            default: w = 8'd80;
        endcase
        return w;
    endfunction

    logic [5:0] position_reg, position_next;
    logic [6:0] minute_reg,   minute_next;
    logic [5:0] hour_reg,     hour_next;
    logic [5:0] day_reg,      day_next;
    logic [4:0] month_reg,    month_next;
    logic [7:0] year_reg,     year_next;
    logic       parity_reg,   parity_next;
    logic       pending_reg,  pending_next;

    logic       in_zero, in_one, in_start;
    logic       bit_val, clear;
    logic [7:0] w_min, w_hour, w_day, w_mon, w_year;
    logic [5:0] off_min, off_hour, off_day, off_mon, off_year;
    logic [6:0] dec_minute;
    logic [5:0] dec_hour;
    logic       date_ok;

    // Classify the interval against the windows (all bounds exclusive)
    assign in_zero  = (beat.pulse_ms > cfg.zero_min_ms) && (beat.pulse_ms < cfg.zero_max_ms);
    assign in_one   = (beat.pulse_ms > cfg.one_min_ms) && (beat.pulse_ms < cfg.one_max_ms);
    assign in_start = (beat.pulse_ms > cfg.start_min_ms) && (beat.pulse_ms < cfg.start_max_ms);

    // Pick BCD weights from the offset inside each field
    assign off_min  = position_reg - POS_MIN0;
    assign off_hour = position_reg - POS_HOUR0;
    assign off_day  = position_reg - POS_DAY0;
    assign off_mon  = position_reg - POS_MON0;
    assign off_year = position_reg - POS_YEAR0;
    assign w_min    = bcd_weight(off_min[2:0]);
    assign w_hour   = bcd_weight(off_hour[2:0]);
    assign w_day    = bcd_weight(off_day[2:0]);
    assign w_mon    = bcd_weight(off_mon[2:0]);
    assign w_year   = bcd_weight(off_year[2:0]);

    // Step back one minute, borrowing from the hour
    assign dec_minute = (minute_reg != '0) ? minute_reg - 7'd1 : LAST_MINUTE;
    assign dec_hour   = (minute_reg != '0) ? hour_reg :
                        ((hour_reg != '0) ? hour_reg - 6'd1 : LAST_HOUR);
    assign date_ok    = ((day_reg != '0) || (month_reg != '0) || (year_reg != '0))
                        && !((dec_minute == '0) && (dec_hour == '0));

    // Walk the frame and build the result
    always_comb
    begin
        position_next = position_reg;
        minute_next   = minute_reg;
        hour_next     = hour_reg;
        day_next      = day_reg;
        month_next    = month_reg;
        year_next     = year_reg;
        parity_next   = parity_reg;
        pending_next  = pending_reg;
        clear         = 1'b0;
        bit_val       = in_zero ? 1'b0 : 1'b1;
        res           = '0;

        if (beat.pulse_ms != '0)
        begin
            if (beat.pin_level)
            begin
                if (in_zero || in_one)
                begin
                    res.pulse_class = in_zero ? 3'(CLS_ZERO) : 3'(CLS_ONE);
                    if (position_reg == '0)
                    begin
                        // ignore bits while waiting for the minute mark
                    end
                    else if (position_reg < POS_START_BIT)
                    begin
                        position_next = position_reg + 6'd1;
                    end
                    else if (position_reg == POS_START_BIT)
                    begin
                        if (!bit_val)
                            clear = 1'b1;
                        position_next = position_reg + 6'd1;
                    end
                    else if (position_reg < POS_MIN_PAR)
                    begin
                        if (bit_val)
                            minute_next = minute_reg + w_min[6:0];
                        parity_next   = parity_reg ^ bit_val;
                        position_next = position_reg + 6'd1;
                    end
                    else if (position_reg == POS_MIN_PAR || position_reg == POS_HOUR_PAR)
                    begin
                        if (parity_reg != bit_val)
                            clear = 1'b1;
                        parity_next   = 1'b0;
                        position_next = position_reg + 6'd1;
                        if (position_reg == POS_HOUR_PAR)
                            pending_next = 1'b1;
                    end
                    else if (position_reg < POS_HOUR_PAR)
                    begin
                        if (bit_val)
                            hour_next = hour_reg + w_hour[5:0];
                        parity_next   = parity_reg ^ bit_val;
                        position_next = position_reg + 6'd1;
                    end
                    else if (position_reg < POS_DOW0)
                    begin
                        if (bit_val)
                            day_next = day_reg + w_day[5:0];
                        parity_next   = parity_reg ^ bit_val;
                        position_next = position_reg + 6'd1;
                    end
                    else if (position_reg < POS_MON0)
                    begin
                        parity_next   = parity_reg ^ bit_val;
                        position_next = position_reg + 6'd1;
                    end
                    else if (position_reg < POS_YEAR0)
                    begin
                        if (bit_val)
                            month_next = month_reg + w_mon[4:0];
                        parity_next   = parity_reg ^ bit_val;
                        position_next = position_reg + 6'd1;
                    end
                    else if (position_reg < POS_DATE_PAR)
                    begin
                        if (bit_val)
                            year_next = year_reg + w_year;
                        parity_next   = parity_reg ^ bit_val;
                        position_next = position_reg + 6'd1;
                    end
                    else if (position_reg == POS_DATE_PAR)
                    begin
                        if (parity_reg != bit_val)
                            clear = 1'b1;
                        position_next = '0;
                        parity_next   = 1'b0;
                    end
                    else
                    begin
                        clear = 1'b1;
                    end
                end
                else
                begin
                    // bad high pulse: class stays idle
                    clear = 1'b1;
                end
            end
            else
            begin
                res.pulse_class = 3'(CLS_GAP);
                if (in_start)
                begin
                    res.pulse_class = 3'(CLS_START);
                    position_next   = 6'd1;
                end
                if (pending_reg)
                begin
                    res.commit           = 1'b1;
                    res.date_from_signal = date_ok;
                    res.out_minute       = dec_minute;
                    res.out_hour         = dec_hour;
                    res.out_day   = date_ok ? day_reg   : {1'b0, beat.clock_day};
                    res.out_month = date_ok ? month_reg : {1'b0, beat.clock_month};
                    res.out_year  = date_ok ? year_reg  : {1'b0, beat.clock_year};
                    minute_next  = '0;
                    hour_next    = '0;
                    day_next     = '0;
                    month_next   = '0;
                    year_next    = '0;
                    pending_next = 1'b0;
                end
            end
        end

        // Drop the whole decode on any failure
        if (clear)
        begin
            position_next = '0;
            minute_next   = '0;
            hour_next     = '0;
            day_next      = '0;
            month_next    = '0;
            year_next     = '0;
            parity_next   = 1'b0;
            pending_next  = 1'b0;
        end

        res.decode_failed  = clear;
        res.frame_position = position_next;
    end

    // Advance decoder state once per consumed beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            minute_reg   <= '0;
            hour_reg     <= '0;
            day_reg      <= '0;
            month_reg    <= '0;
            year_reg     <= '0;
            parity_reg   <= 1'b0;
            pending_reg  <= 1'b0;
        end
        else if (step)
        begin
            position_reg <= position_next;
            minute_reg   <= minute_next;
            hour_reg     <= hour_next;
            day_reg      <= day_next;
            month_reg    <= month_next;
            year_reg     <= year_next;
            parity_reg   <= parity_next;
            pending_reg  <= pending_next;
        end
    end

    a_position_range: assert property (@(posedge clk) disable iff (!rst_n)
        position_reg <= POS_DATE_PAR)
        else $error("frame position beyond frame end");

    a_fail_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.decode_failed |=> position_reg == '0 && !pending_reg && minute_reg == '0)
        else $error("failure did not clear decoder state");

    a_commit_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.commit |-> pending_reg)
        else $error("commit without a pending hour parity");

    a_commit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.commit |=> !pending_reg && day_reg == '0 && year_reg == '0)
        else $error("commit did not clear decoded fields");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import dcf_pkg::*;

    // Frame positions of the time code
    localparam int POS_START_BIT = 21;
    localparam int POS_MIN0      = 22;
    localparam int POS_MIN_PAR   = 29;
    localparam int POS_HOUR0     = 30;
    localparam int POS_HOUR_PAR  = 36;
    localparam int POS_DAY0      = 37;
    localparam int POS_DOW0      = 43;
    localparam int POS_MON0      = 46;
    localparam int POS_YEAR0     = 51;
    localparam int POS_DATE_PAR  = 59;

    // How the clock date of a beat is chosen
    localparam int CLK_RAND = 0;
    localparam int CLK_LOW  = 1;
    localparam int CLK_HIGH = 2;

    localparam int HOLD_CYCLES = 150;

    // Decoder state mirror plus the queue of results still owed by the block
    class dcf_frame_scoreboard;
        dcf_cfg_t    win;
        logic [5:0]  pos;
        logic [6:0]  min_acc;
        logic [5:0]  hour_acc;
        logic [5:0]  day_acc;
        logic [4:0]  month_acc;
        logic [7:0]  year_acc;
        bit          par;
        bit          pending;
        dcf_result_t results_due[$];
        int          errors;
        int          n_beats;
        int          n_checked;
        int          n_commits;
        int          n_dated;
        int          n_failed;

        function new();
            win.zero_min_ms  = ZERO_MIN_DEFAULT;
            win.zero_max_ms  = ZERO_MAX_DEFAULT;
            win.one_min_ms   = ONE_MIN_DEFAULT;
            win.one_max_ms   = ONE_MAX_DEFAULT;
            win.start_min_ms = START_MIN_DEFAULT;
            win.start_max_ms = START_MAX_DEFAULT;
            clear_frame();
            errors    = 0;
            n_beats   = 0;
            n_checked = 0;
            n_commits = 0;
            n_dated   = 0;
            n_failed  = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_ZERO_MIN:  win.zero_min_ms  = val;
                CFG_ZERO_MAX:  win.zero_max_ms  = val;
                CFG_ONE_MIN:   win.one_min_ms   = val;
                CFG_ONE_MAX:   win.one_max_ms   = val;
                CFG_START_MIN: win.start_min_ms = val;
                CFG_START_MAX: win.start_max_ms = val;
                default: ;
            endcase
        endfunction

        function void clear_frame();
            pos       = '0;
            min_acc   = '0;
            hour_acc  = '0;
            day_acc   = '0;
            month_acc = '0;
            year_acc  = '0;
            par       = 1'b0;
            pending   = 1'b0;
        endfunction

        function logic [7:0] bcd_weight(int k);
            case (k & 7)
                0: return 8'd1;
                1: return 8'd2;
                2: return 8'd4;
                3: return 8'd8;
                4: return 8'd10;
                5: return 8'd20;
                6: return 8'd40;
                default: return 8'd80;
            endcase
        endfunction

        // Advance the frame walk by one data bit; return 1 when decoding fails
        function bit take_bit(bit b);
            int p;
            p = pos;
            if (p == 0)
                return 1'b0;
            if (p < POS_START_BIT)
                pos = 6'(p + 1);
            else if (p == POS_START_BIT)
            begin
                if (!b)
                begin
                    clear_frame();
                    return 1'b1;
                end
                pos = 6'(p + 1);
            end
            else if (p < POS_MIN_PAR)
            begin
                if (b)
                    min_acc = 7'(min_acc + bcd_weight(p - POS_MIN0));
                par ^= b;
                pos = 6'(p + 1);
            end
            else if (p == POS_MIN_PAR || p == POS_HOUR_PAR)
            begin
                if (par != b)
                begin
                    clear_frame();
                    return 1'b1;
                end
                par = 1'b0;
                pos = 6'(p + 1);
                if (p == POS_HOUR_PAR)
                    pending = 1'b1;
            end
            else if (p < POS_HOUR_PAR)
            begin
                if (b)
                    hour_acc = 6'(hour_acc + bcd_weight(p - POS_HOUR0));
                par ^= b;
                pos = 6'(p + 1);
            end
            else if (p < POS_DOW0)
            begin
                if (b)
                    day_acc = 6'(day_acc + bcd_weight(p - POS_DAY0));
                par ^= b;
                pos = 6'(p + 1);
            end
            else if (p < POS_MON0)
            begin
                par ^= b;
                pos = 6'(p + 1);
            end
            else if (p < POS_YEAR0)
            begin
                if (b)
                    month_acc = 5'(month_acc + bcd_weight(p - POS_MON0));
                par ^= b;
                pos = 6'(p + 1);
            end
            else if (p < POS_DATE_PAR)
            begin
                if (b)
                    year_acc = 8'(year_acc + bcd_weight(p - POS_YEAR0));
                par ^= b;
                pos = 6'(p + 1);
            end
            else if (p == POS_DATE_PAR)
            begin
                if (par != b)
                begin
                    clear_frame();
                    return 1'b1;
                end
                pos = '0;
                par = 1'b0;
            end
            else
            begin
                clear_frame();
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // Classify one interval and work out the result it causes
        function dcf_result_t decode_pulse(dcf_beat_t b);
            dcf_result_t r;
            logic [6:0]  m;
            logic [5:0]  h;
            bit          date_ok;
            r = '0;
            if (b.pulse_ms != 0)
            begin
                if (b.pin_level)
                begin
                    if (b.pulse_ms > win.zero_min_ms && b.pulse_ms < win.zero_max_ms)
                    begin
                        r.pulse_class   = CLS_ZERO;
                        r.decode_failed = take_bit(1'b0);
                    end
                    else if (b.pulse_ms > win.one_min_ms && b.pulse_ms < win.one_max_ms)
                    begin
                        r.pulse_class   = CLS_ONE;
                        r.decode_failed = take_bit(1'b1);
                    end
                    else
                    begin
                        clear_frame();
                        r.decode_failed = 1'b1;
                    end
                end
                else
                begin
                    r.pulse_class = CLS_GAP;
                    if (b.pulse_ms > win.start_min_ms && b.pulse_ms < win.start_max_ms)
                    begin
                        r.pulse_class = CLS_START;
                        pos = 6'd1;
                    end
                    // Deliver the pending time, one minute back
                    if (pending)
                    begin
                        date_ok = (day_acc != 0) || (month_acc != 0) || (year_acc != 0);
                        m = min_acc;
                        h = hour_acc;
                        if (m != 0)
                            m = m - 7'd1;
                        else
                        begin
                            m = 7'd59;
                            h = (h != 0) ? h - 6'd1 : 6'd23;
                        end
                        if (m == 0 && h == 0)
                            date_ok = 1'b0;
                        r.commit     = 1'b1;
                        r.out_minute = m;
                        r.out_hour   = h;
                        if (date_ok)
                        begin
                            r.date_from_signal = 1'b1;
                            r.out_day   = day_acc;
                            r.out_month = month_acc;
                            r.out_year  = year_acc;
                        end
                        else
                        begin
                            r.out_day   = {1'b0, b.clock_day};
                            r.out_month = {1'b0, b.clock_month};
                            r.out_year  = {1'b0, b.clock_year};
                        end
                        min_acc   = '0;
                        hour_acc  = '0;
                        day_acc   = '0;
                        month_acc = '0;
                        year_acc  = '0;
                        pending   = 1'b0;
                    end
                end
            end
            r.frame_position = pos;
            return r;
        endfunction

        function void note_beat(dcf_beat_t b);
            dcf_result_t r;
            r = decode_pulse(b);
            results_due.push_back(r);
            n_beats++;
            if (r.commit)
                n_commits++;
            if (r.date_from_signal)
                n_dated++;
            if (r.decode_failed)
                n_failed++;
        endfunction

        task check_field(string name, int want, int got);
            if (want != got)
                report($sformatf("result %0d field %s expected %0d got %0d",
                                 n_checked, name, want, got));
        endtask

        task check_result(dcf_result_t got);
            dcf_result_t want;
            if (results_due.size() == 0)
            begin
                report("result beat with no pulse waiting for it");
                return;
            end
            want = results_due.pop_front();
            check_field("pulse_class", want.pulse_class, got.pulse_class);
            check_field("decode_failed", want.decode_failed, got.decode_failed);
            check_field("commit", want.commit, got.commit);
            check_field("date_from_signal", want.date_from_signal, got.date_from_signal);
            check_field("out_minute", want.out_minute, got.out_minute);
            check_field("out_hour", want.out_hour, got.out_hour);
            check_field("out_day", want.out_day, got.out_day);
            check_field("out_month", want.out_month, got.out_month);
            check_field("out_year", want.out_year, got.out_year);
            check_field("frame_position", want.frame_position, got.frame_position);
            n_checked++;
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic                   write_en;
    logic [CFG_INDEX_W-1:0] reg_index;
    logic [CFG_DATA_W-1:0]  write_data;

    dcf_beat_if   pulse_ch ();
    dcf_result_if result_ch ();

    dcf_frame_scoreboard sb = new();

    int n_sent;
    bit tx_idle;
    bit rx_idle;
    bit hold_req;
    int hold_left;

    dcf77_time_code_decoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pulse      (pulse_ch.sink),
        .result     (result_ch.source),
        .write_en   (write_en),
        .reg_index  (reg_index),
        .write_data (write_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Random value strictly inside an exclusive window
    function automatic logic [15:0] in_window(logic [15:0] lo, logic [15:0] hi);
        return 16'($urandom_range(int'(lo) + 1, int'(hi) - 1));
    endfunction

    function automatic bit window_ok(logic [15:0] lo, logic [15:0] hi);
        return (int'(hi) - int'(lo)) >= 2;
    endfunction

    // Nonzero low length that does not mark a minute start
    function automatic logic [15:0] plain_gap();
        logic [15:0] ms;
        for (int tries = 0; tries < 64; tries++)
        begin
            ms = 16'($urandom_range(0, 1) ? $urandom_range(1, 1000)
                                          : $urandom_range(1, 65535));
            if (!(ms > sb.win.start_min_ms && ms < sb.win.start_max_ms))
                return ms;
        end
        return 16'hFFFF;
    endfunction

    // Offer one beat, with random idle cycles first when tx_idle is set, and hold it until taken
    task automatic send_beat(input dcf_beat_t b);
        if (tx_idle)
            while ($urandom_range(0, 99) < 29)
            begin
                pulse_ch.valid <= 1'b0;
                @(posedge clk);
            end
        pulse_ch.valid <= 1'b1;
        pulse_ch.data  <= b;
        do
            @(posedge clk);
        while (!pulse_ch.ready);
        sb.note_beat(b);
        n_sent++;
    endtask

    task automatic send_pulse(input bit level, input logic [15:0] ms, input int mode);
        dcf_beat_t b;
        b.pin_level = level;
        b.pulse_ms  = ms;
        case (mode)
            CLK_LOW:
            begin
                b.clock_day   = '0;
                b.clock_month = '0;
                b.clock_year  = '0;
            end
            CLK_HIGH:
            begin
                b.clock_day   = 5'd31;
                b.clock_month = 4'd12;
                b.clock_year  = 7'd99;
            end
            default:
            begin
                b.clock_day   = 5'($urandom_range(0, 31));
                b.clock_month = 4'($urandom_range(0, 12));
                b.clock_year  = 7'($urandom_range(0, 99));
            end
        endcase
        send_beat(b);
    endtask

    // Drop valid and wait until every owed result has come back
    task automatic drain();
        pulse_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.results_due.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_config(input dcf_cfg_t c);
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  val;
        for (int i = 0; i <= int'(CFG_START_MAX); i++)
        begin
            idx = CFG_INDEX_W'(i);
            case (idx)
                CFG_ZERO_MIN:  val = c.zero_min_ms;
                CFG_ZERO_MAX:  val = c.zero_max_ms;
                CFG_ONE_MIN:   val = c.one_min_ms;
                CFG_ONE_MAX:   val = c.one_max_ms;
                CFG_START_MIN: val = c.start_min_ms;
                default:       val = c.start_max_ms;
            endcase
            write_en   <= 1'b1;
            reg_index  <= idx;
            write_data <= val;
            @(posedge clk);
            sb.write_reg(idx, val);
        end
        write_en <= 1'b0;
    endtask

    // One minute of time code with random content, sometimes broken or cut short;
    // stop early once the phase has sent its share of beats
    task automatic send_frame(input int stop_at);
        logic [59:0] fb;
        int          gap_mode;
        int          cut;
        int          r;
        fb = 60'({$urandom, $urandom});
        fb[POS_START_BIT] = ($urandom_range(0, 19) != 0);
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            // 00:01 steps back to midnight
            fb[POS_MIN_PAR-1:POS_MIN0]   = 7'd1;
            fb[POS_HOUR_PAR-1:POS_HOUR0] = '0;
        end
        else if (r == 1)
        begin
            // 00:00 wraps to the previous day
            fb[POS_MIN_PAR-1:POS_MIN0]   = '0;
            fb[POS_HOUR_PAR-1:POS_HOUR0] = '0;
        end
        if ($urandom_range(0, 9) == 0)
            fb[POS_DATE_PAR-1:POS_DAY0] = '0;
        fb[POS_MIN_PAR]  = ^fb[POS_MIN_PAR-1:POS_MIN0] ^ ($urandom_range(0, 99) < 5);
        fb[POS_HOUR_PAR] = ^fb[POS_HOUR_PAR-1:POS_HOUR0] ^ ($urandom_range(0, 99) < 5);
        fb[POS_DATE_PAR] = ^fb[POS_DATE_PAR-1:POS_DAY0] ^ ($urandom_range(0, 99) < 5);
        r = $urandom_range(0, 99);
        if (r < 45)
            cut = POS_DATE_PAR + 1;
        else if (r < 80)
            cut = POS_HOUR_PAR + 1;
        else
            cut = $urandom_range(2, POS_DATE_PAR - 1);
        gap_mode = $urandom_range(0, 2);
        send_pulse(1'b0, in_window(sb.win.start_min_ms, sb.win.start_max_ms), CLK_RAND);
        for (int k = 1; k < cut && n_sent < stop_at; k++)
        begin
            if (fb[k])
                send_pulse(1'b1, in_window(sb.win.one_min_ms, sb.win.one_max_ms), CLK_RAND);
            else
                send_pulse(1'b1, in_window(sb.win.zero_min_ms, sb.win.zero_max_ms), CLK_RAND);
            if (gap_mode == 2 || (gap_mode == 1 && $urandom_range(0, 1)))
                send_pulse(1'b0, plain_gap(), CLK_RAND);
        end
    endtask

    // Stray intervals: empty, arbitrary, near a window edge, or short
    task automatic send_noise(input int n);
        logic [15:0] ms;
        bit          level;
        for (int i = 0; i < n; i++)
        begin
            level = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
                0: ms = '0;
                1: ms = 16'($urandom);
                2:
                begin
                    ms = 16'(sb.win >> (CFG_DATA_W * $urandom_range(0, 5)));
                    ms = 16'(ms + $urandom_range(0, 2) - 1);
                end
                default: ms = 16'($urandom_range(1, 300));
            endcase
            send_pulse(level, ms, CLK_RAND);
        end
    endtask

    task automatic run_phase(input int budget);
        int first;
        bit framing;
        first = n_sent;
        framing = window_ok(sb.win.zero_min_ms, sb.win.zero_max_ms)
               && window_ok(sb.win.one_min_ms, sb.win.one_max_ms)
               && window_ok(sb.win.start_min_ms, sb.win.start_max_ms);
        while (n_sent - first < budget)
        begin
            if (framing && $urandom_range(0, 99) < 80)
                send_frame(first + budget);
            else
                send_noise($urandom_range(1, 6));
        end
    endtask

    // Result side: check each taken beat, then pick ready for the next cycle
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
                sb.check_result(result_ch.data);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (rx_idle)
                result_ch.ready <= ($urandom_range(0, 99) >= 29);
            else
                result_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d results still owed", sb.results_due.size());
        $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        dcf_cfg_t cfg;
        n_sent     = 0;
        tx_idle    = 1'b0;
        rx_idle    = 1'b0;
        hold_req   = 1'b0;
        hold_left  = 0;
        rst_n          <= 1'b0;
        pulse_ch.valid <= 1'b0;
        pulse_ch.data  <= '0;
        write_en       <= 1'b0;
        reg_index      <= '0;
        write_data     <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty intervals, bad highs, bits while waiting, window edges
        send_pulse(1'b1, 16'd0, CLK_HIGH);
        send_pulse(1'b0, 16'd0, CLK_LOW);
        send_pulse(1'b1, 16'hFFFF, CLK_HIGH);
        send_pulse(1'b1, 16'd1, CLK_LOW);
        send_pulse(1'b1, 16'd100, CLK_HIGH);
        send_pulse(1'b1, 16'd200, CLK_LOW);
        send_pulse(1'b0, 16'hFFFF, CLK_HIGH);
        send_pulse(1'b0, 16'd1, CLK_LOW);
        send_pulse(1'b0, 16'd1601, CLK_HIGH);
        send_pulse(1'b1, 16'd41, CLK_LOW);
        send_pulse(1'b1, 16'd229, CLK_HIGH);
        send_pulse(1'b1, 16'd130, CLK_LOW);
        send_pulse(1'b0, 16'd1999, CLK_HIGH);
        send_pulse(1'b0, 16'd1600, CLK_LOW);
        send_pulse(1'b1, 16'd129, CLK_HIGH);
        send_pulse(1'b1, 16'd140, CLK_LOW);
        send_pulse(1'b0, 16'd2000, CLK_HIGH);
        drain();

        // Default windows, both sides idling at random
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        run_phase(140);
        drain();

        // Wide windows reaching the register extremes; stall the result side
        cfg = '{16'd0, 16'd90, 16'd90, 16'hFFFF, 16'd1000, 16'hFFFF};
        write_config(cfg);
        hold_req = 1'b1;
        run_phase(130);
        drain();

        // Narrow windows with short start gaps
        cfg = '{16'd300, 16'd400, 16'd500, 16'd700, 16'd0, 16'd500};
        write_config(cfg);
        run_phase(130);
        drain();

        // Empty windows: every high interval fails, no low one starts a frame
        cfg = '{16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0};
        write_config(cfg);
        run_phase(30);
        drain();

        // Back to defaults at full rate, no idling on either side
        cfg = '{ZERO_MIN_DEFAULT, ZERO_MAX_DEFAULT, ONE_MIN_DEFAULT, ONE_MAX_DEFAULT,
                START_MIN_DEFAULT, START_MAX_DEFAULT};
        write_config(cfg);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        run_phase(110);
        drain();
        repeat (10) @(posedge clk);

        if (sb.results_due.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.results_due.size()));
        $display("covered %0d pulses over 5 window settings, %0d results checked",
                 sb.n_beats, sb.n_checked);
        $display("decoded times delivered %0d (%0d with date from signal), failures %0d",
                 sb.n_commits, sb.n_dated, sb.n_failed);
        if (sb.errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/dcf_pkg.sv
rtl/core/dcf_beat_if.sv
rtl/core/dcf_result_if.sv
rtl/core/dcf_frame.sv
rtl/core/dcf77_time_code_decoder.sv
dv/tb_top.sv
